@@ rtl/core/timer_queue_with_rearm_top_defines.svh @@
// Assertion macros for the timer queue checker.
// Included by the checker file only.
`ifndef TIMER_QUEUE_WITH_REARM_TOP_DEFINES_SVH
`define TIMER_QUEUE_WITH_REARM_TOP_DEFINES_SVH
`define TQR_ASSERT_IMPL(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("tqr check failed");
`define TQR_ASSERT(lbl, prop) `TQR_ASSERT_IMPL(lbl, clk, rst, prop)
`endif

@@ rtl/core/tqr_pkg.sv @@
// Shared types and constants for the timer queue.
// No dependencies.
`default_nettype none
package tqr_pkg;
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_STOP  = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;
  localparam logic [1:0] KIND_FIRE  = 2'd0;
  localparam logic [1:0] KIND_PROG  = 2'd1;
  localparam logic [1:0] KIND_STOP  = 2'd2;
  localparam logic [1:0] KIND_LEAVE = 2'd3;
  localparam logic [31:0] COUNT_CLAMP = 32'hFFFFFFFF;
  localparam logic [3:0] MAX_SHIFT = 4'd8;
  localparam logic [15:0] TPU_RESET = 16'd100;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  slot;
    logic [31:0] timeout_us;
    logic        repeat_req;
    logic [63:0] now_us;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  fired_slot;
    logic [3:0]  pre_shift;
    logic [31:0] count;
    logic        last;
  } out_item_t;

  // Scan token passed along the cell chain: best candidate so far.
  typedef struct packed {
    logic        found;
    logic [63:0] dl;
  } scan_t;

  // Broadcast command to all cells.
  typedef struct packed {
    logic        wr;       // write start
    logic        clr;      // disarm addressed slot
    logic        fire;     // fire winner of previous scan
    logic        due_only; // scan only expired, not done
    logic        clr_done;
    logic [63:0] now;
    logic [31:0] timeout;
    logic        rep;
  } cell_cmd_t;
endpackage
`default_nettype wire

@@ rtl/core/tqr_if.sv @@
// Valid/ready channel interface for timer queue items.
// Depends on tqr_pkg.
`default_nettype none
interface tqr_in_if;
  logic valid;
  logic ready;
  tqr_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tqr_out_if;
  logic valid;
  logic ready;
  tqr_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/timer_queue_with_rearm_top.sv @@
// Channel     | dir | payload
// in          | in  | mode, slot, timeout_us, repeat_req, now_us
// out         | out | kind, fired_slot, pre_shift, count, last
// apb         | in  | ticks_per_us at address 0
// One item at a time. A scan moves the token one cell a cycle and is read
// at the chain's end. Start, stop and mode 3 take one scan, plus the
// counter programming (one step per halving) when the counter is loaded.
// A tick adds one due scan, plus one scan and one fire beat per expired slot.
// Reset is synchronous; all slots come up disarmed. Output stalls hold
// the fire and emit states; the output register parts the two sides.
`default_nettype none
module timer_queue_with_rearm_top #(
  parameter int SLOTS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  tqr_in_if.sink in,
  tqr_out_if.source out,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [0:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  localparam int IW = (SLOTS > 16) ? $clog2(SLOTS) : 4;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_SCAN = 7'b0000010, S_FIRE = 7'b0000100,
    S_FINAL = 7'b0001000, S_PROG = 7'b0010000, S_WAIT = 7'b0100000,
    S_EMIT = 7'b1000000
  } st_t;
  st_t st;

  logic [15:0] tpu;
  tqr_pkg::in_item_t it;
  tqr_pkg::cell_cmd_t cmd;
  tqr_pkg::scan_t chain [SLOTS+1];
  logic [IW-1:0] ids [SLOTS+1];
  tqr_pkg::scan_t best;
  logic [IW-1:0] best_id;
  logic skip;
  logic [63:0] pdelay;
  logic pstart, pdone;
  logic [3:0] pshift;
  logic [31:0] pcount;
  logic in_range;
  logic emit;
  logic [8:0] cnt;
  logic scan_end;
  logic [63:0] start_dl;
  tqr_pkg::out_item_t fin;

  assign pready = 1'b1;
  assign prdata = {16'd0, tpu};
  always_ff @(posedge clk) begin
    if (rst) tpu <= tqr_pkg::TPU_RESET;
    else if (psel && penable && pwrite && paddr == 1'b0) tpu <= pwdata[15:0];
  end

  assign in_range = ({28'd0, it.slot} < SLOTS);
  assign in.ready = (st == S_IDLE);
  assign emit = !out.valid || out.ready;
  assign scan_end = (cnt == 9'(SLOTS));
  assign start_dl = it.now_us + {32'd0, it.timeout_us};

  assign chain[0] = '0;
  assign ids[0] = '0;
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    tqr_cell #(.IW(IW)) u_cell (
      .clk, .rst, .my_id(IW'(g)), .sel_id(IW'(it.slot)), .win_id(best_id),
      .cmd, .skip, .scan_in(chain[g]), .id_in(ids[g]),
      .scan_out(chain[g+1]), .id_out(ids[g+1])
    );
  end

  always_comb begin
    cmd = '0;
    cmd.now = it.now_us;
    cmd.timeout = it.timeout_us;
    cmd.rep = it.repeat_req;
    cmd.due_only = (st == S_SCAN);
    cmd.fire = (st == S_FIRE) && emit;
    cmd.wr = (st == S_PROG) && (it.mode == tqr_pkg::MODE_START) && in_range;
    cmd.clr = (st == S_FINAL) && (it.mode == tqr_pkg::MODE_STOP) && in_range;
    cmd.clr_done = in.valid && in.ready;
    skip = (st == S_FINAL) &&
           ((it.mode == tqr_pkg::MODE_START) || (it.mode == tqr_pkg::MODE_STOP));
  end

  tqr_prog u_prog (
    .clk, .rst, .start(pstart), .delay(pdelay), .tpu,
    .done(pdone), .shift(pshift), .count(pcount)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      out.valid <= 1'b0;
      pstart <= 1'b0;
      cnt <= 9'd0;
    end else begin
      pstart <= 1'b0;
      cnt <= ((st == S_SCAN || st == S_FINAL) && !scan_end) ? cnt + 9'd1 : 9'd0;
      if (out.valid && out.ready && st != S_FIRE && st != S_EMIT) out.valid <= 1'b0;
      case (st)
        S_IDLE: if (in.valid) begin
          it <= in.data;
          st <= (in.data.mode == tqr_pkg::MODE_TICK) ? S_SCAN : S_FINAL;
        end
        S_SCAN: if (scan_end) begin
          best <= chain[SLOTS];
          best_id <= ids[SLOTS];
          st <= chain[SLOTS].found ? S_FIRE : S_FINAL;
        end
        S_FIRE: if (emit) begin
          out.valid <= 1'b1;
          out.data <= '{tqr_pkg::KIND_FIRE, best_id[3:0], 4'd0, 32'd0, 1'b0};
          st <= S_SCAN;
        end
        S_FINAL: if (scan_end) begin
          best <= chain[SLOTS];
          best_id <= ids[SLOTS];
          st <= S_PROG;
        end
        S_PROG: begin
          case (it.mode)
            tqr_pkg::MODE_START: begin
              if (in_range && (!best.found || best.dl > start_dl ||
                  (best.dl == start_dl && best_id > IW'(it.slot)))) begin
                pdelay <= {32'd0, it.timeout_us}; pstart <= 1'b1; st <= S_WAIT;
              end else begin
                fin <= '{tqr_pkg::KIND_LEAVE, 4'd0, 4'd0, 32'd0, 1'b1};
                st <= S_EMIT;
              end
            end
            tqr_pkg::MODE_STOP: begin
              if (in_range && !best.found) begin
                fin <= '{tqr_pkg::KIND_STOP, 4'd0, 4'd0, 32'd0, 1'b1};
                st <= S_EMIT;
              end else if (in_range && it.now_us < best.dl) begin
                pdelay <= best.dl - it.now_us; pstart <= 1'b1; st <= S_WAIT;
              end else begin
                fin <= '{tqr_pkg::KIND_LEAVE, 4'd0, 4'd0, 32'd0, 1'b1};
                st <= S_EMIT;
              end
            end
            tqr_pkg::MODE_TICK: begin
              if (best.found) begin
                pdelay <= (best.dl > it.now_us) ? best.dl - it.now_us : 64'd0;
                pstart <= 1'b1;
                st <= S_WAIT;
              end else begin
                fin <= '{tqr_pkg::KIND_LEAVE, 4'd0, 4'd0, 32'd0, 1'b1};
                st <= S_EMIT;
              end
            end
            default: begin
              fin <= '{tqr_pkg::KIND_LEAVE, 4'd0, 4'd0, 32'd0, 1'b1};
              st <= S_EMIT;
            end
          endcase
        end
        S_WAIT: if (pdone) begin
          fin <= '{tqr_pkg::KIND_PROG, 4'd0, pshift, pcount, 1'b1};
          st <= S_EMIT;
        end
        S_EMIT: if (emit) begin
          out.valid <= 1'b1;
          out.data <= fin;
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/tqr_cell.sv @@
// One timer slot cell: holds deadline, period, armed, done; compares with
// the incoming scan token and registers the better one for the next cell.
// Depends on tqr_pkg.
`default_nettype none
module tqr_cell #(
  parameter int IW = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic [IW-1:0] my_id,
  input  wire logic [IW-1:0] sel_id,
  input  wire logic [IW-1:0] win_id,
  input  wire tqr_pkg::cell_cmd_t cmd,
  input  wire logic skip,
  input  wire tqr_pkg::scan_t scan_in,
  input  wire logic [IW-1:0] id_in,
  output tqr_pkg::scan_t scan_out,
  output logic [IW-1:0] id_out
);
  logic [63:0] deadline;
  logic [31:0] period;
  logic armed, done;
  logic me, win, cand;

  assign me = (sel_id == my_id);
  assign win = (win_id == my_id);
  assign cand = armed && !(skip && me) &&
                !(cmd.due_only && (done || deadline > cmd.now));

  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= 1'b0;
      done <= 1'b0;
      scan_out <= '0;
      id_out <= '0;
    end else begin
      if (cand && (!scan_in.found || deadline < scan_in.dl)) begin
        scan_out.found <= 1'b1;
        scan_out.dl <= deadline;
        id_out <= my_id;
      end else begin
        scan_out <= scan_in;
        id_out <= id_in;
      end
      if (cmd.clr_done) done <= 1'b0;
      if (cmd.wr && me) begin
        armed <= 1'b1;
        deadline <= cmd.now + {32'd0, cmd.timeout};
        period <= cmd.rep ? cmd.timeout : 32'd0;
      end
      if (cmd.clr && me) armed <= 1'b0;
      if (cmd.fire && win) begin
        done <= 1'b1;
        if (period != 32'd0) deadline <= cmd.now + {32'd0, period};
        else armed <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/tqr_prog.sv @@
// Counter programming unit: delay times ticks_per_us, halved one step a
// cycle until it fits 32 bits (2^40 and up clamp). Depends on tqr_pkg.
`default_nettype none
module tqr_prog (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic [63:0] delay,
  input  wire logic [15:0] tpu,
  output logic done,
  output logic [3:0] shift,
  output logic [31:0] count
);
  typedef enum logic [3:0] {
    P_IDLE = 4'b0001, P_MUL = 4'b0010, P_SUM = 4'b0100, P_NORM = 4'b1000
  } ph_t;
  ph_t ph;
  logic [31:0] dhi, dlo;
  logic [47:0] hi;
  logic [47:0] lo;
  logic [40:0] p;
  logic zero, sat;
  logic [63:0] sum;

  assign sum = {hi[31:0], 32'd0} + {16'd0, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      ph <= P_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (ph)
        P_IDLE: if (start) begin
          dhi <= delay[63:32];
          dlo <= delay[31:0];
          zero <= (delay == 64'd0);
          ph <= P_MUL;
        end
        P_MUL: begin
          hi <= {16'd0, dhi} * {32'd0, tpu};
          lo <= {16'd0, dlo} * {32'd0, tpu};
          ph <= P_SUM;
        end
        P_SUM: begin
          shift <= 4'd0;
          sat <= (hi >= 48'd256) || (sum >= 64'h100_0000_0000);
          p <= sum[40:0];
          ph <= P_NORM;
        end
        P_NORM: begin
          if (zero || (!sat && p == 41'd0)) begin
            shift <= 4'd0; count <= 32'd1; done <= 1'b1; ph <= P_IDLE;
          end else if (sat) begin
            shift <= tqr_pkg::MAX_SHIFT; count <= tqr_pkg::COUNT_CLAMP;
            done <= 1'b1; ph <= P_IDLE;
          end else if (p[40:32] != 9'd0) begin
            p <= p >> 1;
            shift <= shift + 4'd1;
          end else begin
            count <= p[31:0]; done <= 1'b1; ph <= P_IDLE;
          end
        end
        default: ph <= P_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/tqr_checker.sv @@
// Port-level checks for the timer queue; bound to the top level.
// Depends on the defines header.
`default_nettype none
`include "timer_queue_with_rearm_top_defines.svh"
module tqr_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_last,
  input wire logic [1:0] out_kind
);
  `TQR_ASSERT(a_fire_not_last, out_valid && out_kind == tqr_pkg::KIND_FIRE |-> !out_last)
  `TQR_ASSERT(a_final_last, out_valid && out_kind != tqr_pkg::KIND_FIRE |-> out_last)
  `TQR_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready)
  `TQR_ASSERT(a_hold, out_valid && !out_ready |=> out_valid)
endmodule

bind timer_queue_with_rearm_top tqr_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in.valid), .in_ready(in.ready),
  .out_valid(out.valid), .out_ready(out.ready), .out_last(out.data.last),
  .out_kind(out.data.kind)
);
`default_nettype wire

@@ verif/timer_queue_with_rearm_top_tb.sv @@
// Testbench for the timer queue with re-arm: directed table then random beats,
// every result checked against an in-bench model of the slot queue or a hand-typed value.
// Depends on tqr_pkg, tqr_if and timer_queue_with_rearm_top.
`timescale 1ns / 1ps
module timer_queue_with_rearm_top_tb;
  localparam int NSLOT = 16;
  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam logic [0:0] ADDR_TPU = 1'b0;
  localparam int CYCLE_LIMIT = 1000000;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [0:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  tqr_in_if in_ch ();
  tqr_out_if out_ch ();

  timer_queue_with_rearm_top #(.SLOTS(NSLOT)) dut (
    .clk(clk), .rst(rst), .in(in_ch), .out(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // model state
  logic [63:0] dl_q [NSLOT];
  logic [31:0] per_q [NSLOT];
  logic        armed_q [NSLOT];
  logic [15:0] tpu_q;
  tqr_pkg::out_item_t pending_q [$];

  int errors;
  int cycles;
  bit calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(string field, tqr_pkg::out_item_t got, tqr_pkg::out_item_t want);
    $display("mismatch %s: got kind=%0d slot=%0d sh=%0d cnt=%h last=%0d, %s",
             field, got.kind, got.fired_slot, got.pre_shift, got.count, got.last,
             $sformatf("want kind=%0d slot=%0d sh=%0d cnt=%h last=%0d",
                       want.kind, want.fired_slot, want.pre_shift, want.count,
                       want.last));
    errors++;
  endtask

  function automatic tqr_pkg::out_item_t final_beat(logic [1:0] kind);
    tqr_pkg::out_item_t r;
    r = '0;
    r.kind = kind;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic tqr_pkg::out_item_t counter_setting(logic [63:0] delay);
    logic [79:0] p;
    tqr_pkg::out_item_t r;
    int s;
    r = final_beat(tqr_pkg::KIND_PROG);
    p = {16'd0, delay} * {64'd0, tpu_q};
    s = 0;
    if (p == 80'd0) begin
      r.count = 32'd1;
    end else if (p >= (80'd1 << 40)) begin
      r.pre_shift = tqr_pkg::MAX_SHIFT;
      r.count = tqr_pkg::COUNT_CLAMP;
    end else begin
      while (p > {48'd0, tqr_pkg::COUNT_CLAMP}) begin
        p = p >> 1;
        s++;
      end
      r.pre_shift = 4'(s);
      r.count = p[31:0];
    end
    return r;
  endfunction

  function automatic int earliest_slot(int skip);
    int best;
    best = -1;
    for (int i = 0; i < NSLOT; i++) begin
      if (armed_q[i] && i != skip && (best < 0 || dl_q[i] < dl_q[best])) best = i;
    end
    return best;
  endfunction

  task automatic predict_beat(tqr_pkg::in_item_t it);
    int e, best;
    bit done [NSLOT];
    tqr_pkg::out_item_t f;
    case (it.mode)
      tqr_pkg::MODE_START: begin
        dl_q[it.slot] = it.now_us + {32'd0, it.timeout_us};
        per_q[it.slot] = it.repeat_req ? it.timeout_us : 32'd0;
        e = earliest_slot(int'(it.slot));
        armed_q[it.slot] = 1'b1;
        if (e < 0 || dl_q[e] > dl_q[it.slot] ||
            (dl_q[e] == dl_q[it.slot] && e > int'(it.slot)))
          pending_q.push_back(counter_setting({32'd0, it.timeout_us}));
        else
          pending_q.push_back(final_beat(tqr_pkg::KIND_LEAVE));
      end
      tqr_pkg::MODE_STOP: begin
        armed_q[it.slot] = 1'b0;
        e = earliest_slot(-1);
        if (e < 0) pending_q.push_back(final_beat(tqr_pkg::KIND_STOP));
        else if (it.now_us < dl_q[e])
          pending_q.push_back(counter_setting(dl_q[e] - it.now_us));
        else pending_q.push_back(final_beat(tqr_pkg::KIND_LEAVE));
      end
      tqr_pkg::MODE_TICK: begin
        for (int i = 0; i < NSLOT; i++) done[i] = 1'b0;
        forever begin
          best = -1;
          for (int i = 0; i < NSLOT; i++) begin
            if (armed_q[i] && !done[i] && dl_q[i] <= it.now_us &&
                (best < 0 || dl_q[i] < dl_q[best])) best = i;
          end
          if (best < 0) break;
          done[best] = 1'b1;
          if (per_q[best] != 32'd0) dl_q[best] = it.now_us + {32'd0, per_q[best]};
          else armed_q[best] = 1'b0;
          f = '0;
          f.kind = tqr_pkg::KIND_FIRE;
          f.fired_slot = 4'(best);
          pending_q.push_back(f);
        end
        e = earliest_slot(-1);
        if (e < 0) pending_q.push_back(final_beat(tqr_pkg::KIND_LEAVE));
        else pending_q.push_back(counter_setting(dl_q[e] > it.now_us ?
                                                 dl_q[e] - it.now_us : 64'd0));
      end
      default: pending_q.push_back(final_beat(tqr_pkg::KIND_LEAVE));
    endcase
  endtask

  // typed: expectation given by hand, single-beat results only
  task automatic send_beat(tqr_pkg::in_item_t it, bit typed, tqr_pkg::out_item_t want);
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    if (typed) begin
      predict_beat(it);
      void'(pending_q.pop_back());
      pending_q.push_back(want);
    end else begin
      predict_beat(it);
    end
  endtask

  task automatic write_tpu(logic [15:0] v);
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_TPU;
    pwdata <= {16'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tpu_q = v;
  endtask

  function automatic tqr_pkg::in_item_t mk(logic [1:0] mode, logic [3:0] slot,
                                           logic [31:0] t, logic rep, logic [63:0] now);
    tqr_pkg::in_item_t it;
    it.mode = mode;
    it.slot = slot;
    it.timeout_us = t;
    it.repeat_req = rep;
    it.now_us = now;
    return it;
  endfunction

  // output stall bursts
  int stall_left;
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= (stall_left == 1);
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 18);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    tqr_pkg::out_item_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_q.size() == 0) begin
        report("unexpected beat", got, '0);
      end else begin
        want = pending_q.pop_front();
        if (got.kind != want.kind) report("kind", got, want);
        if (got.fired_slot != want.fired_slot) report("fired_slot", got, want);
        if (got.pre_shift != want.pre_shift) report("pre_shift", got, want);
        if (got.count != want.count) report("count", got, want);
        if (got.last != want.last) report("last", got, want);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  typedef struct {
    tqr_pkg::in_item_t it;
    bit typed;
    tqr_pkg::out_item_t want;
  } row_t;

  row_t rows [$];
  logic [63:0] now_t;
  logic [15:0] tpu_set [5];
  tqr_pkg::in_item_t it;
  tqr_pkg::out_item_t nul;
  int r;

  task automatic add(tqr_pkg::in_item_t it, bit typed, tqr_pkg::out_item_t want);
    row_t x;
    x.it = it;
    x.typed = typed;
    x.want = want;
    rows.push_back(x);
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    calm = 1'b0;
    nul = '0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = ADDR_TPU;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b1;
    tpu_q = tqr_pkg::TPU_RESET;
    for (int i = 0; i < NSLOT; i++) begin
      dl_q[i] = '0;
      per_q[i] = '0;
      armed_q[i] = 1'b0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add(mk(tqr_pkg::MODE_TICK, 4'd0, 32'd0, 1'b0, 64'd0), 1,
        final_beat(tqr_pkg::KIND_LEAVE));
    add(mk(tqr_pkg::MODE_STOP, 4'd3, 32'd0, 1'b0, 64'd0), 1,
        final_beat(tqr_pkg::KIND_STOP));
    add(mk(MODE_NONE, 4'd15, 32'hFFFFFFFF, 1'b1, 64'hFFFFFFFFFFFFFFFF), 1,
        final_beat(tqr_pkg::KIND_LEAVE));
    add(mk(tqr_pkg::MODE_START, 4'd0, 32'd0, 1'b0, 64'd0), 1,
        '{kind: tqr_pkg::KIND_PROG, fired_slot: 4'd0, pre_shift: 4'd0, count: 32'd1,
          last: 1'b1});
    add(mk(tqr_pkg::MODE_START, 4'd15, 32'hFFFFFFFF, 1'b1, 64'd0), 0, nul);
    add(mk(tqr_pkg::MODE_TICK, 4'd0, 32'd0, 1'b0, 64'd0), 0, nul);
    add(mk(tqr_pkg::MODE_START, 4'd5, 32'd10, 1'b1, 64'd100), 0, nul);
    add(mk(tqr_pkg::MODE_START, 4'd6, 32'd10, 1'b0, 64'd100), 0, nul);
    add(mk(tqr_pkg::MODE_START, 4'd4, 32'd10, 1'b0, 64'd100), 0, nul);
    add(mk(tqr_pkg::MODE_TICK, 4'd0, 32'd0, 1'b0, 64'd110), 0, nul);
    add(mk(tqr_pkg::MODE_STOP, 4'd6, 32'd0, 1'b0, 64'd110), 0, nul);
    add(mk(tqr_pkg::MODE_START, 4'd9, 32'd0, 1'b1, 64'hFFFFFFFFFFFFFFFF), 0, nul);
    add(mk(tqr_pkg::MODE_START, 4'd2, 32'd5, 1'b1, 64'hFFFFFFFFFFFFFFFE), 0, nul);
    add(mk(tqr_pkg::MODE_TICK, 4'd0, 32'd0, 1'b0, 64'hFFFFFFFFFFFFFFFF), 0, nul);
    add(mk(tqr_pkg::MODE_TICK, 4'd0, 32'd0, 1'b0, 64'd3), 0, nul);
    add(mk(tqr_pkg::MODE_STOP, 4'd5, 32'd0, 1'b0, 64'd3), 0, nul);
    add(mk(tqr_pkg::MODE_STOP, 4'd15, 32'd0, 1'b0, 64'd3), 0, nul);
    add(mk(tqr_pkg::MODE_STOP, 4'd2, 32'd0, 1'b0, 64'd3), 0, nul);
    add(mk(tqr_pkg::MODE_STOP, 4'd9, 32'd0, 1'b0, 64'd3), 0, nul);
    foreach (rows[i]) send_beat(rows[i].it, rows[i].typed, rows[i].want);

    tpu_set[0] = 16'd1;
    tpu_set[1] = 16'd65535;
    tpu_set[2] = 16'($urandom_range(1, 65535));
    tpu_set[3] = 16'd7;
    tpu_set[4] = tqr_pkg::TPU_RESET;
    now_t = 64'd1000;
    for (int ph = 0; ph < 5; ph++) begin
      write_tpu(tpu_set[ph]);
      calm = (ph == 4);
      for (int n = 0; n < 50; n++) begin
        if ($urandom_range(0, 39) == 0) now_t = {32'($urandom), 32'($urandom)};
        it = mk(2'($urandom_range(0, 3)), 4'($urandom), 32'($urandom), 1'($urandom),
                now_t);
        r = $urandom_range(0, 99);
        if (r < 40) begin
          it.mode = tqr_pkg::MODE_START;
          if ($urandom_range(0, 4) != 0) it.timeout_us = $urandom_range(0, 200);
        end else if (r < 55) begin
          it.mode = tqr_pkg::MODE_STOP;
        end else if (r < 95) begin
          it.mode = tqr_pkg::MODE_TICK;
          now_t = now_t + 64'($urandom_range(0, 150));
          it.now_us = now_t;
        end else begin
          it.mode = MODE_NONE;
          it.now_us = {32'($urandom), 32'($urandom)};
        end
        send_beat(it, 0, nul);
      end
    end
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
